// ----- rtl/duplicate_sequence_window_assert.svh -----
// Assertion helpers for the duplicate sequence window block.
`ifndef DUPLICATE_SEQUENCE_WINDOW_ASSERT_SVH
`define DUPLICATE_SEQUENCE_WINDOW_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DSW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("duplicate_sequence_window: check failed");

// Next-cycle implication, checked out of reset.
`define DSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("duplicate_sequence_window: check failed");

`endif

// ----- rtl/dsw_pkg.sv -----
`default_nettype none
package dsw_pkg;

    localparam int SEQ_W = 16;
    localparam int ID_W  = 8;

    // Control decided for one request after the state read.
    typedef struct packed {
        logic we;   // write back the updated entry
        logic dup;  // request reports a duplicate
    } t_upd_ctl;

endpackage
`default_nettype wire

// ----- rtl/dsw_ram.sv -----
`default_nettype none
module dsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    i_clk,
    i_we,
    i_waddr,
    i_wdata,
    i_raddr,
    o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  wire logic             i_clk;
    input  wire logic             i_we;
    input  wire logic [AW-1:0]    i_waddr;
    input  wire logic [WIDTH-1:0] i_wdata;
    input  wire logic [AW-1:0]    i_raddr;
    output logic      [WIDTH-1:0] o_rdata;

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/dsw_update.sv -----
`default_nettype none
module dsw_update #(
    parameter int WINDOW_BITS = 8
) (
    i_in_range,
    i_high,
    i_mask,
    i_seq,
    o_ctl,
    o_high,
    o_mask
);
    import dsw_pkg::*;

    localparam int IW = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;

    input  wire logic                    i_in_range;
    input  wire logic [dsw_pkg::SEQ_W-1:0] i_high;
    input  wire logic [WINDOW_BITS-1:0]  i_mask;
    input  wire logic [dsw_pkg::SEQ_W-1:0] i_seq;
    output dsw_pkg::t_upd_ctl            o_ctl;
    output logic [dsw_pkg::SEQ_W-1:0]    o_high;
    output logic [WINDOW_BITS-1:0]       o_mask;

    logic [SEQ_W-1:0] diff;
    logic [SEQ_W-1:0] behind;
    logic             ahead;
    logic             in_win;
    logic [IW-1:0]    bidx;
    logic             seen;

    always_comb begin
        diff   = i_seq - i_high;
        behind = SEQ_W'(~diff + 1'b1);
        ahead  = (diff != '0) && !diff[SEQ_W-1];
        in_win = !ahead && (behind < SEQ_W'(WINDOW_BITS));
        bidx   = behind[IW-1:0];
        seen   = i_mask[bidx];

        o_high = i_high;
        o_mask = i_mask;
        o_ctl  = '{we: 1'b0, dup: 1'b1};

        if (!i_in_range) begin
            o_ctl = '{we: 1'b0, dup: 1'b1};
        end else if (ahead) begin
            // slide the window forward and mark the new head
            o_high = i_seq;
            if (diff >= SEQ_W'(WINDOW_BITS)) begin
                o_mask = WINDOW_BITS'(1);
            end else begin
                o_mask = (i_mask << diff) | WINDOW_BITS'(1);
            end
            o_ctl = '{we: 1'b1, dup: 1'b0};
        end else if (in_win) begin
            o_mask = i_mask | (WINDOW_BITS'(1) << bidx);
            o_ctl  = '{we: 1'b1, dup: seen};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/duplicate_sequence_window.sv -----
`default_nettype none
// Per-sender duplicate frame filter.
// Request channel: drive i_sender_id and i_sequence_req with start high; the
// request is taken at a rising edge where start is high and busy is low.
// Result channel: o_is_duplicate is valid for exactly one cycle while o_valid
// is high; the receiver cannot hold it off.
// Each sender owns one entry in two memories: the highest sequence seen and
// a WINDOW_BITS-wide mask of recently seen sequences.
// The memory read is issued at the request edge; the next cycle updates, writes
// back and registers the result, and o_valid rises at the end of that cycle.
// No new request is taken during the read-modify-write of the per-sender
// entry; busy stays high for the update cycle and interlocks the next read
// against the pending write.
// Reset (i_rst_n low, synchronous) clears one valid flag per sender; an entry
// without its flag reads as zero, so no memory clearing pass is needed and
// requests are taken in the first cycle after reset.
// A sender id at or above SENDER_COUNT reports a duplicate and changes nothing.
module duplicate_sequence_window #(
    parameter int SENDER_COUNT = 256,
    parameter int WINDOW_BITS  = 8
) (
    i_clk,
    i_rst_n,
    start,
    busy,
    i_sender_id,
    i_sequence_req,
    o_valid,
    o_is_duplicate
);
    import dsw_pkg::*;

    localparam int AW = (SENDER_COUNT > 1) ? $clog2(SENDER_COUNT) : 1;

    input  wire logic                      i_clk;
    input  wire logic                      i_rst_n;
    input  wire logic                      start;
    output logic                           busy;
    input  wire logic [dsw_pkg::ID_W-1:0]  i_sender_id;
    input  wire logic [dsw_pkg::SEQ_W-1:0] i_sequence_req;
    output logic                           o_valid;
    output logic                           o_is_duplicate;

    logic                    accept;
    logic [AW-1:0]           rd_addr;
    logic [SEQ_W-1:0]        high_rd;
    logic [WINDOW_BITS-1:0]  mask_rd;
    logic [SEQ_W-1:0]        high_cur;
    logic [WINDOW_BITS-1:0]  mask_cur;
    logic [SEQ_W-1:0]        high_nxt;
    logic [WINDOW_BITS-1:0]  mask_nxt;
    t_upd_ctl                ctl;
    logic                    mem_we;

    logic                    r_busy;
    logic [AW-1:0]           r_addr;
    logic [SEQ_W-1:0]        r_seq;
    logic                    r_in_range;
    logic                    r_hit;
    logic [SENDER_COUNT-1:0] r_valid;
    logic [SENDER_COUNT-1:0] n_valid;
    logic                    r_out_valid;
    logic                    r_out_dup;

    assign accept  = start && !r_busy;
    assign busy    = r_busy;
    assign rd_addr = i_sender_id[AW-1:0];
    assign mem_we  = r_busy && ctl.we;

    dsw_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (SENDER_COUNT)
    ) u_high_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata (high_nxt),
        .i_raddr (rd_addr),
        .o_rdata (high_rd)
    );

    dsw_ram #(
        .WIDTH (WINDOW_BITS),
        .DEPTH (SENDER_COUNT)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata (mask_nxt),
        .i_raddr (rd_addr),
        .o_rdata (mask_rd)
    );

    // entries never written since reset read as zero
    assign high_cur = r_hit ? high_rd : '0;
    assign mask_cur = r_hit ? mask_rd : '0;

    dsw_update #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_update (
        .i_in_range (r_in_range),
        .i_high     (high_cur),
        .i_mask     (mask_cur),
        .i_seq      (r_seq),
        .o_ctl      (ctl),
        .o_high     (high_nxt),
        .o_mask     (mask_nxt)
    );

    always_comb begin
        n_valid = r_valid;
        if (mem_we) begin
            n_valid[r_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= accept;
            r_valid     <= n_valid;
            r_out_valid <= r_busy;
        end
    end

    // hold the request fields across the read cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr     <= rd_addr;
            r_seq      <= i_sequence_req;
            r_in_range <= ({1'b0, i_sender_id} < (ID_W + 1)'(SENDER_COUNT));
            r_hit      <= r_valid[rd_addr];
        end
        if (r_busy) begin
            r_out_dup <= ctl.dup;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_is_duplicate = r_out_dup;

`include "duplicate_sequence_window_assert.svh"

    `DSW_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_busy)
    `DSW_ASSERT_NEXT(a_busy_result, i_clk, i_rst_n, r_busy, o_valid && !r_busy)
    `DSW_ASSERT_NOW(a_no_write_out_of_range, i_clk, i_rst_n, r_busy && !r_in_range, !mem_we)
    `DSW_ASSERT_NOW(a_no_stray_write, i_clk, i_rst_n, !r_busy, !mem_we)

endmodule
`default_nettype wire
